FILE: design/dss_pkg.sv
// Shared types and constants for the shortest-seek-first disk request scheduler.
`timescale 1ns / 1ps

package dss_pkg;

    // Queue storage and its index and count widths
    localparam int STORE_SLOTS = 32;
    localparam int IDX_W       = 5;
    localparam int CNT_W       = 6;
    localparam int CYL_W       = 16;
    localparam int TOTAL_W     = 21;

    // Input word kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [CYL_W-1:0] cylinder;
    } t_in_word;

    typedef struct packed {
        logic [CYL_W-1:0]   served_cylinder;
        logic [CYL_W-1:0]   move_distance;
        logic [TOTAL_W-1:0] total_seek;
        logic               last;
        logic               empty_res;
        logic               overflowed;
    } t_out_word;

    // Control from the sequencer to the nearest-request compare unit
    typedef struct packed {
        logic             clear;
        logic             enable;
        logic [IDX_W-1:0] idx;
    } t_cmp_ctl;

    // Best candidate held by the compare unit
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [CYL_W-1:0] gap;
        logic [CYL_W-1:0] cyl;
    } t_best;

endpackage

FILE: design/dss_nearest.sv
// Shared distance and compare unit that tracks the nearest unserved request.
`timescale 1ns / 1ps

module dss_nearest (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  dss_pkg::t_cmp_ctl       i_ctl,
    input  logic [dss_pkg::CYL_W-1:0] i_head,
    input  logic [dss_pkg::CYL_W-1:0] i_data,
    output dss_pkg::t_best          o_best
);
    import dss_pkg::*;

    logic             r_found;
    t_best            r_best;
    logic [CYL_W-1:0] gap;
    logic             take;

    // Absolute distance from the head to the candidate
    always_comb begin
        if (i_head >= i_data) begin
            gap = i_head - i_data;
        end else begin
            gap = i_data - i_head;
        end
    end

    // Strictly nearer wins, so ties keep the lower index scanned first
    assign take = i_ctl.enable && (!r_found || (gap < r_best.gap));

    // Hold the best candidate, drop it when a new scan begins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && !i_ctl.clear) begin
            r_best.idx <= i_ctl.idx;
            r_best.gap <= gap;
            r_best.cyl <= i_data;
        end
    end

    assign o_best = r_best;

endmodule

FILE: design/disk_sstf_scheduler.sv
// Top level of the shortest-seek-first disk request scheduler: queue, sequencer and results.
// A load word produces no result; busy stays low. A start word with an
// empty queue gives one result on the following cycle, also without raising busy. Otherwise
// the block stays busy through n picks for n queued requests: each pick walks the
// single read port of the request queue over all n entries through one distance compare
// unit, then drains the read register and commits the pick and presents
// its result. Results appear on o_strobe for one cycle each and cannot be held off.
`timescale 1ns / 1ps

module disk_sstf_scheduler #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  dss_pkg::t_in_word  i_word,
    output logic               o_strobe,
    output dss_pkg::t_out_word o_word
);
    import dss_pkg::*;

    // Usable capacity, limited to the storage on hand
    localparam int CAP = (QUEUE_DEPTH < 1) ? 1 :
                         ((QUEUE_DEPTH > STORE_SLOTS) ? STORE_SLOTS : QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_picks;
    logic [IDX_W-1:0]   r_scan_idx;
    logic [CYL_W-1:0]   r_head;
    logic [TOTAL_W-1:0] r_total;
    logic               r_ovf;
    logic [STORE_SLOTS-1:0] r_served;
    logic               r_strobe;
    t_out_word          r_word;

    logic [CYL_W-1:0]   r_mem [STORE_SLOTS];
    logic [CYL_W-1:0]   r_rd_data;
    logic               r_rd_vld;
    logic [IDX_W-1:0]   r_rd_idx;

    logic               accept;
    logic               wr_en;
    logic               rd_en;
    logic [TOTAL_W-1:0] n_total;
    logic               is_last;
    t_cmp_ctl           cmp_ctl;
    t_best              best;

    assign accept  = start && (r_state == ST_IDLE);
    assign wr_en   = accept && (i_word.kind == KIND_LOAD) && (r_count < CNT_W'(CAP));
    assign rd_en   = (r_state == ST_SCAN);
    assign n_total = r_total + TOTAL_W'(best.gap);
    assign is_last = ((r_picks + CNT_W'(1)) == r_count);

    // Request queue: one write port for loads, one registered read port for the scan
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= i_word.cylinder;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_scan_idx];
        end
        r_rd_idx <= r_scan_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
        end
    end

    // Feed the compare unit with each unserved entry as it leaves the read port
    always_comb begin
        cmp_ctl.clear  = (accept && (i_word.kind == KIND_START)) ||
                         ((r_state == ST_PICK) && !is_last);
        cmp_ctl.enable = r_rd_vld && !r_served[r_rd_idx];
        cmp_ctl.idx    = r_rd_idx;
    end

    dss_nearest u_nearest (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cmp_ctl),
        .i_head  (r_head),
        .i_data  (r_rd_data),
        .o_best  (best)
    );

    // Sequencer: load, start, scan over the queue and commit one pick per pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_picks    <= '0;
            r_scan_idx <= '0;
            r_head     <= '0;
            r_total    <= '0;
            r_ovf      <= 1'b0;
            r_served   <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_word.kind == KIND_LOAD) begin
                            if (r_count < CNT_W'(CAP)) begin
                                r_count <= r_count + CNT_W'(1);
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end else begin
                            r_head     <= i_word.cylinder;
                            r_total    <= '0;
                            r_picks    <= '0;
                            r_scan_idx <= '0;
                            if (r_count == '0) begin
                                // Empty start: report at once and clear the overflow mark
                                r_strobe              <= 1'b1;
                                r_word.served_cylinder <= '0;
                                r_word.move_distance   <= '0;
                                r_word.total_seek      <= '0;
                                r_word.last            <= 1'b1;
                                r_word.empty_res       <= 1'b1;
                                r_word.overflowed      <= r_ovf;
                                r_ovf                  <= 1'b0;
                            end else begin
                                r_state <= ST_SCAN;
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    if ({1'b0, r_scan_idx} == (r_count - CNT_W'(1))) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_scan_idx <= r_scan_idx + IDX_W'(1);
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_PICK;
                end
                ST_PICK: begin
                    r_head                 <= best.cyl;
                    r_total                <= n_total;
                    r_strobe               <= 1'b1;
                    r_word.served_cylinder <= best.cyl;
                    r_word.move_distance   <= best.gap;
                    r_word.total_seek      <= n_total;
                    r_word.last            <= is_last;
                    r_word.empty_res       <= 1'b0;
                    r_word.overflowed      <= r_ovf;
                    if (is_last) begin
                        // End of run: empty the queue
                        r_count  <= '0;
                        r_served <= '0;
                        r_ovf    <= 1'b0;
                        r_state  <= ST_IDLE;
                    end else begin
                        r_served[best.idx] <= 1'b1;
                        r_picks            <= r_picks + CNT_W'(1);
                        r_scan_idx         <= '0;
                        r_state            <= ST_SCAN;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_word   = r_word;

endmodule

FILE: sim/tb_disk_sstf_scheduler.sv
// Self-checking testbench for the shortest-seek-first disk request scheduler.
`timescale 1ns / 1ps

module tb_disk_sstf_scheduler;
    import dss_pkg::*;

    localparam int          DEPTH         = 32;
    localparam int          CAPACITY      = (DEPTH < 1) ? 1 :
                                            ((DEPTH > STORE_SLOTS) ? STORE_SLOTS : DEPTH);
    localparam int          LIMIT_CYCLES  = 400000;
    localparam int          SETTLE_CYCLES = 1200;
    localparam int          RANDOM_WORDS  = 90;
    localparam logic [21:0] SEEK_SAT      = 22'h1FFFFF;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    logic      o_strobe;
    t_in_word  i_word  = '0;
    t_out_word o_word;

    // Scoreboard model of the request queue
    logic [CYL_W-1:0] req_cyl [STORE_SLOTS];
    int               req_count   = 0;
    bit               drop_seen   = 1'b0;

    // Words waiting to be sent and picks waiting to be seen
    t_in_word         cmd_q[$];
    t_out_word        pick_q[$];

    int               idle_pct      = 0;
    int               words_sent    = 0;
    int               picks_seen    = 0;
    int               runs_started  = 0;
    int               overflow_runs = 0;
    int               mismatches    = 0;
    int               cycle_count   = 0;

    disk_sstf_scheduler #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_word  (i_word),
        .o_strobe(o_strobe),
        .o_word  (o_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Apply one accepted word to the queue model; a start expands into its picks
    function automatic void predict_schedule(input t_in_word w);
        logic [CYL_W-1:0] head;
        logic [CYL_W-1:0] d;
        logic [CYL_W-1:0] best_d;
        logic [21:0]      seek;
        int               best;
        bit               taken [STORE_SLOTS];
        t_out_word        r;
        if (w.kind == KIND_LOAD) begin
            if (req_count < CAPACITY) begin
                req_cyl[req_count] = w.cylinder;
                req_count++;
            end else begin
                drop_seen = 1'b1;
            end
            return;
        end
        runs_started++;
        if (drop_seen)
            overflow_runs++;
        head = w.cylinder;
        seek = '0;
        if (req_count == 0) begin
            r            = '0;
            r.last       = 1'b1;
            r.empty_res  = 1'b1;
            r.overflowed = drop_seen;
            pick_q.push_back(r);
        end else begin
            foreach (taken[i])
                taken[i] = 1'b0;
            for (int k = 0; k < req_count; k++) begin
                best   = -1;
                best_d = '0;
                // Nearest unserved request, lowest index wins a tie
                for (int i = 0; i < req_count; i++) begin
                    if (!taken[i]) begin
                        d = (head > req_cyl[i]) ? head - req_cyl[i] : req_cyl[i] - head;
                        if (best < 0 || d < best_d) begin
                            best   = i;
                            best_d = d;
                        end
                    end
                end
                taken[best] = 1'b1;
                head        = req_cyl[best];
                seek        = seek + 22'(best_d);
                if (seek > SEEK_SAT)
                    seek = SEEK_SAT;
                r.served_cylinder = head;
                r.move_distance   = best_d;
                r.total_seek      = seek[TOTAL_W-1:0];
                r.last            = (k == req_count - 1);
                r.empty_res       = 1'b0;
                r.overflowed      = drop_seen;
                pick_q.push_back(r);
            end
        end
        req_count = 0;
        drop_seen = 1'b0;
    endfunction

    // Drive the command port: retire an accepted word, then offer the next or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_schedule(i_word);
                void'(cmd_q.pop_front());
                words_sent++;
            end
            if (cmd_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                start  <= 1'b1;
                i_word <= cmd_q[0];
            end else begin
                start  <= 1'b0;
            end
        end
    end

    function automatic void note_mismatch(input string what, input t_out_word want,
                                          input t_out_word got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: expected cyl=%0d dist=%0d total=%0d last=%0b empty=%0b ovf=%0b",
                     what, want.served_cylinder, want.move_distance, want.total_seek,
                     want.last, want.empty_res, want.overflowed);
            $display("    got cyl=%0d dist=%0d total=%0d last=%0b empty=%0b ovf=%0b",
                     got.served_cylinder, got.move_distance, got.total_seek,
                     got.last, got.empty_res, got.overflowed);
        end
    endfunction

    // Compare each strobed result word with the oldest expected pick
    always @(posedge i_clk) begin : check_results
        t_out_word want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (pick_q.size() == 0) begin
                note_mismatch("result with nothing pending", '0, o_word);
            end else begin
                want = pick_q.pop_front();
                picks_seen++;
                if (o_word !== want)
                    note_mismatch("result mismatch", want, o_word);
            end
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL disk_sstf_scheduler");
            $finish;
        end
    end

    task automatic send_word(input logic kind, input logic [CYL_W-1:0] cyl);
        t_in_word w;
        w.kind     = kind;
        w.cylinder = cyl;
        cmd_q.push_back(w);
    endtask

    // Hold until every queued word is taken and every expected pick has arrived
    task automatic wait_quiet();
        while (cmd_q.size() != 0 || pick_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Empty starts and cylinders at both ends of the range
    task automatic test_extremes();
        idle_pct = 9;
        send_word(KIND_START, 16'd0);
        send_word(KIND_LOAD,  16'hFFFF);
        send_word(KIND_LOAD,  16'd0);
        send_word(KIND_LOAD,  16'd0);
        send_word(KIND_LOAD,  16'hFFFF);
        send_word(KIND_START, 16'hFFFF);
        send_word(KIND_START, 16'd12345);
        wait_quiet();
    endtask

    // Equal distances either side of the head, duplicates and zero moves
    task automatic test_ties();
        idle_pct = 9;
        send_word(KIND_LOAD,  16'd500);
        send_word(KIND_LOAD,  16'd100);
        send_word(KIND_LOAD,  16'd300);
        send_word(KIND_LOAD,  16'd40);
        send_word(KIND_LOAD,  16'd40);
        send_word(KIND_START, 16'd300);
        send_word(KIND_LOAD,  16'd7);
        send_word(KIND_START, 16'd7);
        send_word(KIND_LOAD,  16'hAAAA);
        send_word(KIND_LOAD,  16'h5555);
        send_word(KIND_START, 16'h8000);
        wait_quiet();
    endtask

    function automatic logic [CYL_W-1:0] pick_cylinder(input int mode, input int base);
        case (mode)
            0: begin
                return CYL_W'($urandom_range(65535));
            end
            1: begin
                // Narrow cluster on an even grid, so ties and repeats are common
                return CYL_W'(base + 2 * $urandom_range(8));
            end
            default: begin
                case ($urandom_range(2))
                    0:       return '0;
                    1:       return '1;
                    default: return CYL_W'($urandom_range(65535));
                endcase
            end
        endcase
    endfunction

    // Random schedules through three idling phases
    task automatic test_random();
        int  sent;
        int  loads;
        int  mode;
        int  base;
        int  roll;
        bit  full_done;
        sent      = 0;
        full_done = 1'b0;
        while (sent < RANDOM_WORDS) begin
            if (sent < RANDOM_WORDS / 3)
                idle_pct = 9;
            else if (sent < 2 * RANDOM_WORDS / 3)
                idle_pct = 78;
            else
                idle_pct = 0;
            roll = $urandom_range(99);
            if (!full_done && idle_pct == 0) begin
                loads     = CAPACITY + 2;
                full_done = 1'b1;
            end else if (roll < 8) begin
                loads = 0;
            end else if (roll < 70) begin
                loads = $urandom_range(8, 1);
            end else if (roll < 92) begin
                loads = $urandom_range(20, 9);
            end else begin
                loads = $urandom_range(CAPACITY + 3, CAPACITY - 2);
            end
            mode = $urandom_range(2);
            base = $urandom_range(65535 - 16);
            for (int i = 0; i < loads; i++)
                send_word(KIND_LOAD, pick_cylinder(mode, base));
            send_word(KIND_START, pick_cylinder(mode, base + 1));
            sent += loads + 1;
            // Let the start go before the next run is queued
            while (cmd_q.size() != 0)
                @(posedge i_clk);
        end
        wait_quiet();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_ties();
        test_random();

        // Drain: allow for a longest run still in flight before closing
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pick_q.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", pick_q.size());
        end

        $display("Sent %0d words making %0d schedule runs, %0d of them after dropped loads",
                 words_sent, runs_started, overflow_runs);
        $display("Checked %0d result words, %0d mismatches", picks_seen, mismatches);
        if (mismatches == 0) begin
            $display("PASS disk_sstf_scheduler");
        end else begin
            $display("FAIL disk_sstf_scheduler");
        end
        $finish;
    end

endmodule
